@@ design/asgr_pkg.sv @@
// Package for the SGR color parser: state codes, character constants,
// structs between the control and the parameter RAM, and the SGR decode function.
// No dependencies.
`default_nettype none

package asgr_pkg;

   // parameter RAM sizing
   localparam int MAX_PARAMS = 16;
   localparam int PARAM_AW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int COUNT_W    = $clog2(MAX_PARAMS + 1);

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_TERM  = 8'h6D;
   localparam logic [7:0] CH_DIG0  = 8'h30;
   localparam logic [7:0] CH_DIG9  = 8'h39;

   // SGR codes
   localparam logic [7:0] SGR_RESET    = 8'd0;
   localparam logic [7:0] SGR_FG_LO    = 8'd30;
   localparam logic [7:0] SGR_FG_HI    = 8'd37;
   localparam logic [7:0] SGR_FG_DEF   = 8'd39;
   localparam logic [7:0] SGR_BG_LO    = 8'd40;
   localparam logic [7:0] SGR_BG_HI    = 8'd47;
   localparam logic [7:0] SGR_BG_DEF   = 8'd49;
   localparam logic [7:0] SGR_FGB_LO   = 8'd90;
   localparam logic [7:0] SGR_FGB_HI   = 8'd97;
   localparam logic [7:0] SGR_BGB_LO   = 8'd100;
   localparam logic [7:0] SGR_BGB_HI   = 8'd107;
   localparam logic [7:0] NUM_SAT      = 8'd255;

   localparam logic [3:0] FG_DEFAULT = 4'd7;
   localparam logic [3:0] BG_DEFAULT = 4'd0;

   typedef enum logic [1:0] {
      ST_TEXT = 2'd0,
      ST_ESC  = 2'd1,
      ST_SEQ  = 2'd2,
      ST_WALK = 2'd3
   } parse_state_type;

   // packs as the attribute byte: bg high nibble, fg low nibble
   typedef struct packed {
      logic [3:0] bg;
      logic [3:0] fg;
   } color_type;

   typedef struct packed {
      logic                we;
      logic [PARAM_AW-1:0] addr;
      logic [7:0]          data;
   } ram_wr_type;

   typedef struct packed {
      logic                en;
      logic [PARAM_AW-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic       valid;
      color_type  attr;
      logic [7:0] ch;
   } out_item_type;

   function automatic color_type sgr_apply(input logic [7:0] p, input color_type cur);
      color_type nxt;
      nxt = cur;
      if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
         nxt.fg = 4'(p - SGR_FG_LO);
      end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
         nxt.bg = 4'(p - SGR_BG_LO);
      end else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) begin
         nxt.fg = 4'(p - SGR_FGB_LO + 8'd8);
      end else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) begin
         nxt.bg = 4'(p - SGR_BGB_LO + 8'd8);
      end else if (p == SGR_RESET) begin
         nxt.fg = FG_DEFAULT;
         nxt.bg = BG_DEFAULT;
      end else if (p == SGR_FG_DEF) begin
         nxt.fg = FG_DEFAULT;
      end else if (p == SGR_BG_DEF) begin
         nxt.bg = BG_DEFAULT;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

@@ design/asgr_param_ram.sv @@
// Parameter store: single-write, single-read synchronous RAM with a registered read port.
// Depends on asgr_pkg.
`default_nettype none

module asgr_param_ram (
   input  wire logic                        clock,
   input  wire asgr_pkg::ram_wr_type        wr,
   input  wire asgr_pkg::ram_rd_type        rd,
   output logic [7:0]                       rd_data
);
   import asgr_pkg::*;

   logic [7:0] mem [MAX_PARAMS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/asgr_ctrl.sv @@
// Parse sequencer: escape state machine, number builder, parameter writes,
// and the walk that reads stored parameters back and updates the colors.
// Depends on asgr_pkg.
`default_nettype none

module asgr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             in_byte,
   output logic                        ready,
   output asgr_pkg::out_item_type      emit,
   output asgr_pkg::ram_wr_type        ram_wr,
   output asgr_pkg::ram_rd_type        ram_rd,
   input  wire logic [7:0]             ram_rd_data
);
   import asgr_pkg::*;

   parse_state_type     state_ff, state_in;
   logic [7:0]          number_ff, number_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                pending_ff, pending_in;
   color_type           color_ff, color_in;

   logic                byte_live;
   logic [11:0]         num_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_TEXT;
         number_ff   <= '0;
         total_ff    <= '0;
         rd_idx_ff   <= '0;
         pending_ff  <= 1'b0;
         color_ff.fg <= FG_DEFAULT;
         color_ff.bg <= BG_DEFAULT;
      end else begin
         state_ff   <= state_in;
         number_ff  <= number_in;
         total_ff   <= total_in;
         rd_idx_ff  <= rd_idx_in;
         pending_ff <= pending_in;
         color_ff   <= color_in;
      end
   end

   // n*10 + digit, at most 2559
   assign num_next  = ({4'd0, number_ff} << 3) + ({4'd0, number_ff} << 1)
                    + {8'd0, 4'(in_byte - CH_DIG0)};
   assign byte_live = accept && (in_byte != CH_NUL);

   always_comb begin
      state_in    = state_ff;
      number_in   = number_ff;
      total_in    = total_ff;
      rd_idx_in   = rd_idx_ff;
      pending_in  = 1'b0;
      color_in    = color_ff;
      ram_wr.we   = 1'b0;
      ram_wr.addr = total_ff[PARAM_AW-1:0];
      ram_wr.data = number_ff;
      ram_rd.en   = 1'b0;
      ram_rd.addr = rd_idx_ff[PARAM_AW-1:0];
      emit.valid  = 1'b0;
      emit.ch     = in_byte;
      emit.attr   = color_ff;
      ready       = (state_ff != ST_WALK);

      // read data from the previous walk cycle lands here
      if (pending_ff) begin
         color_in = sgr_apply(ram_rd_data, color_ff);
      end

      case (state_ff)
         ST_TEXT: begin
            if (byte_live) begin
               if (in_byte == CH_ESC) begin
                  state_in  = ST_ESC;
                  number_in = '0;
                  total_in  = '0;
               end else begin
                  emit.valid = 1'b1;
               end
            end
         end
         ST_ESC: begin
            if (byte_live) begin
               state_in = (in_byte == CH_LBRK) ? ST_SEQ : ST_TEXT;
            end
         end
         ST_SEQ: begin
            if (byte_live) begin
               if (in_byte inside {[CH_DIG0:CH_DIG9]}) begin
                  number_in = (num_next > {4'd0, NUM_SAT}) ? NUM_SAT : num_next[7:0];
               end else if (in_byte == CH_SEMI || in_byte == CH_TERM) begin
                  if (total_ff < COUNT_W'(MAX_PARAMS)) begin
                     ram_wr.we = 1'b1;
                     total_in  = total_ff + 1'b1;
                  end
                  number_in = '0;
                  if (in_byte == CH_TERM) begin
                     state_in  = ST_WALK;
                     rd_idx_in = '0;
                  end
               end else begin
                  state_in  = ST_TEXT;
                  number_in = '0;
                  total_in  = '0;
               end
            end
         end
         ST_WALK: begin
            if (rd_idx_ff < total_ff) begin
               ram_rd.en  = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               pending_in = 1'b1;
            end else begin
               state_in = ST_TEXT;
               total_in = '0;
            end
         end
         default: begin
            state_in = ST_TEXT;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/ansi_sgr_color_parser_unit.sv @@
// Top level of the ANSI SGR color parser: stream ports, output item register,
// parse sequencer and parameter RAM. Depends on asgr_pkg, asgr_ctrl, asgr_param_ram.
`default_nettype none

// Text bytes enter on req_ and text bytes leave on rsp_ with the color
// attribute that was current when the byte arrived. ESC '[' opens an SGR
// sequence; its bytes, NUL bytes and aborted sequences produce no item.
// Ordinary bytes are taken one per cycle while rsp_ does not stall; an
// output register decouples the sides, so a byte is accepted while the
// previous item is being taken. After the 'm' terminator, req_tready is held
// low while the stored parameters (1 to 16) are read back one per cycle from
// the single-port-read parameter RAM and applied in order, each read's data
// passing the RAM's registered read port. The parameter RAM needs no
// clearing; only entries written in the current sequence are read.
module ansi_sgr_color_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [7:0] out_char, [15:8] out_attribute
);
   import asgr_pkg::*;

   logic          ctrl_ready;
   logic          req_accept;
   out_item_type  emit;
   ram_wr_type    ram_wr;
   ram_rd_type    ram_rd;
   logic [7:0]    ram_rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   // stall on the walk, or when the output register is full and not draining
   assign req_tready = ctrl_ready && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   asgr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_tdata),
      .ready       (ctrl_ready),
      .emit        (emit),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   asgr_param_ram u_param_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   // output item register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {emit.attr, emit.ch};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // no parameter is written while stored ones are walked
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      !ctrl_ready |-> !ram_wr.we)
      else $error("parameter write during walk");

   // the RAM is read only during the walk
   a_read_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_rd.en |-> !ctrl_ready)
      else $error("parameter read outside walk");

   // an item is only produced by an accepted byte
   a_emit_needs_accept: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> req_accept)
      else $error("item produced without accepted byte");

   // a produced item appears on the output in the next cycle
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      emit.valid |=> rsp_tvalid)
      else $error("produced item lost");

endmodule

`default_nettype wire
